/* design/cba_pkg.sv */
package cba_pkg;

    localparam int COORD_W       = 24;
    localparam int CFG_W         = 9;
    localparam int LEN_W         = 40;
    localparam int T_W           = 17;
    localparam int MAX_SUBDIV    = 256;
    localparam logic [CFG_W-1:0] SUBDIV_RESET = CFG_W'(16);
    localparam logic [T_W-1:0]   T_ONE        = T_W'(65536);

endpackage

/* design/cubic_bezier_arc_length_top.sv */
// Per curve: a restoring divider forms 65536 / N, then each chord takes 25 products on the
// shared 35x25 multiplier, then 25 square root steps, the last of which also steps t, and the
// finish state loads the result into the output register.
// A new curve is taken only in the idle state, none while one is in progress; a finished
// result waits in the finish state while the output register holds an untaken result.
// Reset (i_rst_n low at a clock edge) clears the handshakes, idles the sequencer, sets 16 chords.
module cubic_bezier_arc_length_top #(
    parameter int MAX_SUBDIVISIONS = cba_pkg::MAX_SUBDIV
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cba_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [cba_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [cba_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [cba_pkg::COORD_W-1:0] i_ctrl1_x,
    input  logic signed [cba_pkg::COORD_W-1:0] i_ctrl1_y,
    input  logic signed [cba_pkg::COORD_W-1:0] i_ctrl2_x,
    input  logic signed [cba_pkg::COORD_W-1:0] i_ctrl2_y,
    input  logic signed [cba_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [cba_pkg::COORD_W-1:0] i_end_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [cba_pkg::LEN_W-1:0]         o_arc_length
);
    import cba_pkg::*;

    // Count width: it must hold the chord count itself.
    localparam int NW       = $clog2(MAX_SUBDIVISIONS + 1);
    localparam int SQ_W     = 2 * COORD_W + 2;     // sum of two squared chord deltas
    localparam int ROOT_N   = SQ_W / 2;            // one result bit per square root step
    localparam int ACC_W    = 74;                  // exact weighted sum, Q1.48 times Q16.8
    localparam int W_W      = 3 * (T_W - 1) + 1;   // weights up to 2^48
    localparam int PROD_W   = 60;
    localparam int OP_SQX   = 23;
    localparam int OP_SQY   = 24;
    localparam int OP_BLEND = 7;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_CHORD = 5'b00100,
        S_SQRT  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state                    r_state;
    logic [CFG_W-1:0]          r_subdiv;
    logic signed [COORD_W-1:0] r_px [4];
    logic signed [COORD_W-1:0] r_py [4];
    logic signed [COORD_W-1:0] r_prev_x, r_prev_y;
    logic [NW-1:0]             r_n, r_idx, r_drem, r_dr, r_fr;
    logic [T_W-1:0]            r_dq, r_t;
    logic [4:0]                r_cnt;
    logic                      r_ph;
    logic [32:0]               r_t2, r_u2, r_tu;
    logic [W_W-1:0]            r_w [4];
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_accx, r_accy;
    logic [SQ_W-1:0]           r_sv, r_res, r_bit;
    logic [LEN_W-1:0]          r_total;
    logic                      r_o_valid;
    logic [LEN_W-1:0]          r_o_len;

    // Effective chord count: zero counts as one, and the count is clamped to the maximum.
    logic [NW-1:0] n_eff;
    always_comb begin
        if (r_subdiv == '0) begin
            n_eff = NW'(1);
        end else if (32'(r_subdiv) > 32'(MAX_SUBDIVISIONS)) begin
            n_eff = NW'(MAX_SUBDIVISIONS);
        end else begin
            n_eff = NW'(r_subdiv);
        end
    end

    logic [T_W-1:0] u;
    assign u = T_W'(T_ONE - r_t);

    // Restoring divider step for 65536 / n, most significant dividend bit first.
    logic [NW:0] div_sh;
    logic        div_ge;
    assign div_sh = {r_drem, (r_cnt == 5'd0)};
    assign div_ge = div_sh >= {1'b0, r_n};

    // New sample point and chord deltas.
    logic signed [COORD_W-1:0] cx, cy;
    logic signed [COORD_W:0]   dx, dy;
    assign cx = r_accx[71:48];
    assign cy = r_accy[71:48];
    assign dx = {cx[COORD_W-1], cx} - {r_prev_x[COORD_W-1], r_prev_x};
    assign dy = {cy[COORD_W-1], cy} - {r_prev_y[COORD_W-1], r_prev_y};

    // Blend steps: weight index, axis and which half of the weight (the low 24 bits or the rest).
    logic [3:0] bsel;
    logic [1:0] bk;
    assign bsel = 4'(r_cnt - 5'(OP_BLEND));
    assign bk   = bsel[3:2];

    logic [34:0]              mul_a;
    logic [24:0]              mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [COORD_W-1:0] bp;
    always_comb begin
        bp = bsel[1] ? r_py[bk] : r_px[bk];
        case (r_cnt)
            5'd0:    begin mul_a = 35'(r_t);  mul_b = 25'(r_t); end
            5'd1:    begin mul_a = 35'(u);    mul_b = 25'(u);   end
            5'd2:    begin mul_a = 35'(r_t);  mul_b = 25'(u);   end
            5'd3:    begin mul_a = 35'(r_u2); mul_b = 25'(u);   end
            5'd4:    begin mul_a = 35'(r_tu); mul_b = 25'(u);   end
            5'd5:    begin mul_a = 35'(r_tu); mul_b = 25'(r_t); end
            5'd6:    begin mul_a = 35'(r_t2); mul_b = 25'(r_t); end
            5'(OP_SQX): begin mul_a = {{10{dx[COORD_W]}}, dx}; mul_b = dx; end
            5'(OP_SQY): begin mul_a = {{10{dy[COORD_W]}}, dy}; mul_b = dy; end
            default: begin
                mul_a = bsel[0] ? 35'(r_w[bk][23:0]) : 35'(r_w[bk][W_W-1:24]);
                mul_b = {bp[COORD_W-1], bp};
            end
        endcase
        mul_p = $signed(mul_a) * $signed(mul_b);
    end

    // Blend term, the high weight half moved up by 24 bits.
    logic signed [ACC_W-1:0] bterm;
    assign bterm = bsel[0] ? ACC_W'(r_prod) : (ACC_W'(r_prod) <<< 24);

    // Square root step and the running total with saturation.
    logic [SQ_W-1:0]  sq_try, n_sv, n_res;
    logic             sq_ge;
    logic [LEN_W:0]   tot_sum;
    assign sq_try  = r_res + r_bit;
    assign sq_ge   = r_sv >= sq_try;
    assign n_sv    = sq_ge ? r_sv - sq_try : r_sv;
    assign n_res   = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;
    assign tot_sum = {1'b0, r_total} + (LEN_W + 1)'(n_res);

    // Next sample time by adding the quotient and remainder of 65536 / n.
    logic [NW:0]    rsum;
    logic           rwrap;
    assign rsum  = {1'b0, r_fr} + {1'b0, r_dr};
    assign rwrap = rsum >= {1'b0, r_n};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_subdiv  <= SUBDIV_RESET;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            r_ph      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_subdiv <= i_cfg_wdata;
            end
            if (i_out_ready && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_px[0] <= i_start_x; r_py[0] <= i_start_y;
                        r_px[1] <= i_ctrl1_x; r_py[1] <= i_ctrl1_y;
                        r_px[2] <= i_ctrl2_x; r_py[2] <= i_ctrl2_y;
                        r_px[3] <= i_end_x;   r_py[3] <= i_end_y;
                        r_prev_x <= i_start_x;
                        r_prev_y <= i_start_y;
                        r_n      <= n_eff;
                        r_drem   <= '0;
                        r_dq     <= '0;
                        r_cnt    <= '0;
                        r_total  <= '0;
                        r_state  <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_drem <= div_ge ? NW'(div_sh - {1'b0, r_n}) : NW'(div_sh);
                    r_dq   <= {r_dq[T_W-2:0], div_ge};
                    if (r_cnt == 5'(T_W - 1)) begin
                        // First sample time is the quotient itself.
                        r_t     <= {r_dq[T_W-2:0], div_ge};
                        r_dr    <= div_ge ? NW'(div_sh - {1'b0, r_n}) : NW'(div_sh);
                        r_fr    <= div_ge ? NW'(div_sh - {1'b0, r_n}) : NW'(div_sh);
                        r_idx   <= NW'(1);
                        r_cnt   <= '0;
                        r_ph    <= 1'b0;
                        r_state <= S_CHORD;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_CHORD: begin
                    r_ph <= ~r_ph;
                    if (!r_ph) begin
                        r_prod <= mul_p;
                    end else begin
                        r_cnt <= (r_cnt == 5'(OP_SQY)) ? '0 : r_cnt + 5'd1;
                        case (r_cnt)
                            5'd0: begin
                                r_t2   <= r_prod[32:0];
                                r_accx <= '0;
                                r_accy <= '0;
                            end
                            5'd1: r_u2 <= r_prod[32:0];
                            5'd2: r_tu <= r_prod[32:0];
                            5'd3: r_w[0] <= r_prod[W_W-1:0];
                            5'd4: r_w[1] <= r_prod[W_W-1:0] + {r_prod[W_W-2:0], 1'b0};
                            5'd5: r_w[2] <= r_prod[W_W-1:0] + {r_prod[W_W-2:0], 1'b0};
                            5'd6: r_w[3] <= r_prod[W_W-1:0];
                            5'(OP_SQX): r_sv <= r_prod[SQ_W-1:0];
                            5'(OP_SQY): begin
                                r_sv     <= r_sv + r_prod[SQ_W-1:0];
                                r_res    <= '0;
                                r_bit    <= SQ_W'(1) << (SQ_W - 2);
                                r_prev_x <= cx;
                                r_prev_y <= cy;
                                r_state  <= S_SQRT;
                            end
                            default: begin
                                if (bsel[1]) begin
                                    r_accy <= r_accy + bterm;
                                end else begin
                                    r_accx <= r_accx + bterm;
                                end
                            end
                        endcase
                    end
                end
                S_SQRT: begin
                    r_sv  <= n_sv;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (r_cnt == 5'(ROOT_N - 1)) begin
                        r_total <= tot_sum[LEN_W] ? '1 : tot_sum[LEN_W-1:0];
                        r_cnt   <= '0;
                        r_ph    <= 1'b0;
                        if (r_idx == r_n) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx   <= r_idx + NW'(1);
                            r_fr    <= rwrap ? NW'(rsum - {1'b0, r_n}) : NW'(rsum);
                            r_t     <= r_t + r_dq + T_W'(rwrap);
                            r_state <= S_CHORD;
                        end
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_FIN: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_len   <= r_total;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_arc_length = r_o_len;

    // The chord index never runs past the chord count during a curve.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHORD || r_state == S_SQRT) |-> (r_idx <= r_n && r_idx != '0))
        else $error("chord index out of range");

    // The last chord always ends exactly at t = 1.0.
    a_last_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt == 5'(ROOT_N - 1) && r_idx == r_n) |-> (r_t == T_ONE))
        else $error("last sample time is not one");

    // A new result appears only when a curve has been finished.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the finish state");

    // The square root remainder stays within its bound at the end of every root.
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT && r_cnt == 5'(ROOT_N - 1)) |=> (r_sv <= (r_res << 1)))
        else $error("square root remainder too large");

endmodule
